### src/i2cme_pkg.sv
// Package for the I2C master byte engine: word types, command and mode codes.
`timescale 1ns / 1ps
package i2cme_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

    // Configuration register reset values
    localparam logic [7:0] PHASE_TICKS_RST = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    // Command codes carried by an input word
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Sequencer modes
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_START = 3'd1,
        MODE_STOP  = 3'd2,
        MODE_WRITE = 3'd3,
        MODE_READ  = 3'd4
    } t_mode;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [7:0] phase_ticks;
        logic [7:0] ack_timeout;
    } t_cfg;

    // Input word: one tick
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_sample;
    } t_in_word;

    // Result word: line levels and status after the tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       ready_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       no_ack_error;
    } t_out_word;

endpackage

### src/i2cme_seq.sv
// Bus sequencer: state registers and per-tick next-state logic.
`timescale 1ns / 1ps
module i2cme_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  i2cme_pkg::t_in_word i_item,
    input  i2cme_pkg::t_cfg     i_cfg,
    output i2cme_pkg::t_out_word o_res
);

    i2cme_pkg::t_mode r_mode, n_mode;
    logic [3:0] r_sub_step, n_sub_step;
    logic [7:0] r_phase_cnt, n_phase_cnt;
    logic [3:0] r_bit_idx, n_bit_idx;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_wait_cnt, n_wait_cnt;
    logic       r_ack_choice, n_ack_choice;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_rx_hold, n_rx_hold;
    logic       r_err, n_err;

    logic       ph_end;
    logic [7:0] ph_next;
    logic       done;

    // Phase counter: end of phase when count+1 reaches phase_ticks (0 acts as 1)
    assign ph_end  = ({1'b0, r_phase_cnt} + 9'd1) >= {1'b0, i_cfg.phase_ticks};
    assign ph_next = ph_end ? 8'd0 : r_phase_cnt + 8'd1;

    // State registers, updated once per processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= i2cme_pkg::MODE_IDLE;
            r_sub_step   <= 4'd0;
            r_phase_cnt  <= 8'd0;
            r_bit_idx    <= 4'd0;
            r_shift      <= 8'd0;
            r_wait_cnt   <= 8'd0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_rx_hold    <= 8'd0;
            r_err        <= 1'b0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_sub_step   <= n_sub_step;
            r_phase_cnt  <= n_phase_cnt;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
            r_wait_cnt   <= n_wait_cnt;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_rx_hold    <= n_rx_hold;
            r_err        <= n_err;
        end
    end

    // Next state for one tick
    always_comb begin
        n_mode       = r_mode;
        n_sub_step   = r_sub_step;
        n_phase_cnt  = r_phase_cnt;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_wait_cnt   = r_wait_cnt;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_rx_hold    = r_rx_hold;
        n_err        = r_err;
        done         = 1'b0;

        case (r_mode)
            i2cme_pkg::MODE_IDLE: begin
                n_phase_cnt = 8'd0;
                n_sub_step  = 4'd0;
                case (i_item.command)
                    i2cme_pkg::CMD_START: begin
                        n_mode = i2cme_pkg::MODE_START;
                        n_scl  = 1'b1;
                        n_sda  = 1'b1;
                    end
                    i2cme_pkg::CMD_STOP: begin
                        n_mode = i2cme_pkg::MODE_STOP;
                        n_scl  = 1'b0;
                        n_sda  = 1'b0;
                    end
                    i2cme_pkg::CMD_WRITE: begin
                        n_mode    = i2cme_pkg::MODE_WRITE;
                        n_shift   = i_item.tx_byte;
                        n_bit_idx = 4'd0;
                        n_err     = 1'b0;
                        n_scl     = 1'b0;
                        n_sda     = i_item.tx_byte[7];
                    end
                    i2cme_pkg::CMD_READ: begin
                        n_mode       = i2cme_pkg::MODE_READ;
                        n_shift      = 8'd0;
                        n_bit_idx    = 4'd0;
                        n_ack_choice = i_item.send_ack;
                        n_scl        = 1'b0;
                        n_sda        = 1'b1;
                    end
                    default: ;  // no command or unknown code
                endcase
            end

            i2cme_pkg::MODE_START: begin
                n_phase_cnt = ph_next;
                if (ph_end) begin
                    if (r_sub_step == 4'd0) begin
                        n_sda      = 1'b0;
                        n_sub_step = 4'd1;
                    end else begin
                        n_scl  = 1'b0;
                        n_mode = i2cme_pkg::MODE_IDLE;
                        done   = 1'b1;
                    end
                end
            end

            i2cme_pkg::MODE_STOP: begin
                n_phase_cnt = ph_next;
                if (ph_end) begin
                    if (r_sub_step == 4'd0) begin
                        n_scl      = 1'b1;
                        n_sub_step = 4'd1;
                    end else begin
                        n_sda  = 1'b1;
                        n_mode = i2cme_pkg::MODE_IDLE;
                        done   = 1'b1;
                    end
                end
            end

            i2cme_pkg::MODE_WRITE: begin
                if (r_sub_step == 4'd5) begin
                    // ack wait: sample every tick
                    if (!i_item.sda_sample) begin
                        n_scl  = 1'b0;
                        n_mode = i2cme_pkg::MODE_IDLE;
                        done   = 1'b1;
                    end else if (r_wait_cnt >= i_cfg.ack_timeout) begin
                        // timeout: flag and run a stop
                        n_err       = 1'b1;
                        n_mode      = i2cme_pkg::MODE_STOP;
                        n_sub_step  = 4'd0;
                        n_phase_cnt = 8'd0;
                        n_scl       = 1'b0;
                        n_sda       = 1'b0;
                    end else begin
                        n_wait_cnt = r_wait_cnt + 8'd1;
                    end
                end else begin
                    n_phase_cnt = ph_next;
                    if (ph_end) begin
                        case (r_sub_step)
                            4'd0: begin
                                n_scl      = 1'b1;
                                n_sub_step = 4'd1;
                            end
                            4'd1: begin
                                n_scl      = 1'b0;
                                n_sub_step = 4'd2;
                            end
                            4'd2: begin
                                n_bit_idx = r_bit_idx + 4'd1;
                                n_shift   = {r_shift[6:0], 1'b0};
                                if (n_bit_idx < 4'd8) begin
                                    n_sda      = r_shift[6];
                                    n_sub_step = 4'd0;
                                end else begin
                                    n_sub_step = 4'd3;
                                end
                            end
                            4'd3: begin
                                n_sda      = 1'b1;
                                n_scl      = 1'b0;
                                n_sub_step = 4'd4;
                            end
                            default: begin
                                n_scl      = 1'b1;
                                n_wait_cnt = 8'd0;
                                n_sub_step = 4'd5;
                            end
                        endcase
                    end
                end
            end

            i2cme_pkg::MODE_READ: begin
                n_phase_cnt = ph_next;
                if (ph_end) begin
                    case (r_sub_step)
                        4'd0: begin
                            n_scl      = 1'b1;
                            n_sub_step = 4'd1;
                        end
                        4'd1: begin
                            n_shift    = {r_shift[6:0], i_item.sda_sample};
                            n_sub_step = 4'd2;
                        end
                        4'd2: begin
                            n_scl     = 1'b0;
                            n_bit_idx = r_bit_idx + 4'd1;
                            if (n_bit_idx < 4'd8) begin
                                n_sub_step = 4'd0;
                            end else begin
                                n_sda      = !r_ack_choice;
                                n_sub_step = 4'd3;
                            end
                        end
                        4'd3: begin
                            n_scl      = 1'b1;
                            n_sub_step = 4'd4;
                        end
                        default: begin
                            n_scl     = 1'b0;
                            n_rx_hold = r_shift;
                            n_mode    = i2cme_pkg::MODE_IDLE;
                            done      = 1'b1;
                        end
                    endcase
                end
            end

            default: n_mode = i2cme_pkg::MODE_IDLE;
        endcase
    end

    // Result word from the post-tick state
    always_comb begin
        o_res.scl_level    = n_scl;
        o_res.sda_level    = n_sda;
        o_res.ready_res    = (n_mode == i2cme_pkg::MODE_IDLE);
        o_res.done_res     = done;
        o_res.rx_byte      = n_rx_hold;
        o_res.no_ack_error = n_err;
    end

endmodule

### src/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: channels, config registers, word registers.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one tick per
//   word: a command, the byte to write, the ACK choice for a read and the
//   sampled SDA level. The command is acted on only while the engine is idle.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
//   word per input word: SCL and SDA drive, ready, done pulse, last read byte
//   and the no-ack flag, all as they stand after that tick.
//   Path: an accepted word is held in the input register; when it is processed,
//   its result goes to the output register, which presents it until taken.
//   Throughput: one word per cycle when not stalled; next state is combinational.
//   A stalled receiver holds the output word; the input register still takes a
//   word, and o_in_ready drops only while both registers are full and stalled.
//   Config: i_cfg_we writes register i_cfg_idx (0 phase_ticks, 1 ack_timeout)
//   with the low byte of i_cfg_wdata; write only while idle.
//   Reset (synchronous, active low): both registers empty, lines released high,
//   engine idle, phase_ticks 2, ack_timeout 250, rx byte and no-ack flag cleared.
module i2c_master_byte_engine_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  i2cme_pkg::t_in_word           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output i2cme_pkg::t_out_word          o_out_data,
    input  logic                          i_cfg_we,
    input  logic [i2cme_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_wdata
);

    i2cme_pkg::t_cfg      r_cfg;
    logic                 r_in_valid;
    i2cme_pkg::t_in_word  r_in_word;
    logic                 r_out_valid;
    i2cme_pkg::t_out_word r_out_word;
    i2cme_pkg::t_out_word step_res;
    logic                 advance;

    // Process the held word when the output slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks <= i2cme_pkg::PHASE_TICKS_RST;
            r_cfg.ack_timeout <= i2cme_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2cme_pkg::REG_PHASE_TICKS: r_cfg.phase_ticks <= i_cfg_wdata;
                i2cme_pkg::REG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_data;
        end
    end

    // Sequencer
    i2cme_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in_word),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

    // Checks
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted word not held in input register");

    a_out_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed word not presented on output");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.done_res) |-> o_out_data.ready_res)
        else $error("done reported while engine busy");

endmodule

### tb/sv/tb_top.sv
// Testbench for the I2C master byte engine: tick stimulus, line-level prediction, checks.
`timescale 1ns / 1ps
module tb_top;

    // Sub-step where a write samples SDA for the slave ACK
    localparam logic [3:0] ACK_WAIT_STEP = 4'd5;

    // Sequencer state as seen from the bus
    typedef struct {
        i2cme_pkg::t_mode mode;
        logic [3:0] step;
        logic [7:0] pcount;
        logic [3:0] bidx;
        logic [7:0] shreg;
        logic [7:0] wcount;
        logic       ack_sel;
        logic       scl;
        logic       sda;
        logic [7:0] rx;
        logic       err;
    } t_bus_state;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    i2cme_pkg::t_in_word in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    i2cme_pkg::t_out_word out_data;
    logic cfg_we = 1'b0;
    logic [i2cme_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [7:0] cfg_wdata = '0;

    // Configuration as currently programmed
    logic [7:0] phase_len = i2cme_pkg::PHASE_TICKS_RST;
    logic [7:0] ack_limit = i2cme_pkg::ACK_TIMEOUT_RST;

    // Lookahead copy shapes the stimulus; checked copy follows accepted words
    t_bus_state lookahead_bus;
    t_bus_state checked_bus;

    i2cme_pkg::t_in_word  tick_q[$];
    i2cme_pkg::t_out_word expected_levels_q[$];
    int mismatches = 0;
    int results_seen = 0;
    int ticks_planned = 0;
    bit idle_en = 1'b1;

    i2c_master_byte_engine_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_bus_state bus_after_reset();
        t_bus_state s;
        s.mode    = i2cme_pkg::MODE_IDLE;
        s.step    = '0;
        s.pcount  = '0;
        s.bidx    = '0;
        s.shreg   = '0;
        s.wcount  = '0;
        s.ack_sel = 1'b0;
        s.scl     = 1'b1;
        s.sda     = 1'b1;
        s.rx      = '0;
        s.err     = 1'b0;
        return s;
    endfunction

    // One tick of the sequencer; r gets the line levels and status after it
    task automatic advance_bus(inout t_bus_state s, input i2cme_pkg::t_in_word w,
                               output i2cme_pkg::t_out_word r);
        logic ended;
        logic fin;
        fin = 1'b0;
        ended = 1'b0;
        // phase counter runs in every busy state except the ACK wait
        if (s.mode != i2cme_pkg::MODE_IDLE &&
            !(s.mode == i2cme_pkg::MODE_WRITE && s.step == ACK_WAIT_STEP)) begin
            ended = ({1'b0, s.pcount} + 9'd1 >= {1'b0, phase_len});
            s.pcount = ended ? 8'd0 : s.pcount + 8'd1;
        end
        case (s.mode)
            i2cme_pkg::MODE_IDLE: begin
                s.pcount = '0;
                s.step = '0;
                case (w.command)
                    i2cme_pkg::CMD_START: begin
                        s.mode = i2cme_pkg::MODE_START;
                        s.scl = 1'b1;
                        s.sda = 1'b1;
                    end
                    i2cme_pkg::CMD_STOP: begin
                        s.mode = i2cme_pkg::MODE_STOP;
                        s.scl = 1'b0;
                        s.sda = 1'b0;
                    end
                    i2cme_pkg::CMD_WRITE: begin
                        s.mode = i2cme_pkg::MODE_WRITE;
                        s.shreg = w.tx_byte;
                        s.bidx = '0;
                        s.err = 1'b0;
                        s.scl = 1'b0;
                        s.sda = w.tx_byte[7];
                    end
                    i2cme_pkg::CMD_READ: begin
                        s.mode = i2cme_pkg::MODE_READ;
                        s.shreg = '0;
                        s.bidx = '0;
                        s.ack_sel = w.send_ack;
                        s.scl = 1'b0;
                        s.sda = 1'b1;
                    end
                    default: ;
                endcase
            end
            i2cme_pkg::MODE_START: begin
                if (ended) begin
                    if (s.step == 4'd0) begin
                        s.sda = 1'b0;
                        s.step = 4'd1;
                    end else begin
                        s.scl = 1'b0;
                        s.mode = i2cme_pkg::MODE_IDLE;
                        fin = 1'b1;
                    end
                end
            end
            i2cme_pkg::MODE_STOP: begin
                if (ended) begin
                    if (s.step == 4'd0) begin
                        s.scl = 1'b1;
                        s.step = 4'd1;
                    end else begin
                        s.sda = 1'b1;
                        s.mode = i2cme_pkg::MODE_IDLE;
                        fin = 1'b1;
                    end
                end
            end
            i2cme_pkg::MODE_WRITE: begin
                if (s.step == ACK_WAIT_STEP) begin
                    if (!w.sda_sample) begin
                        s.scl = 1'b0;
                        s.mode = i2cme_pkg::MODE_IDLE;
                        fin = 1'b1;
                    end else if (s.wcount >= ack_limit) begin
                        // no ACK in time: flag it and release the bus with a stop
                        s.err = 1'b1;
                        s.mode = i2cme_pkg::MODE_STOP;
                        s.step = '0;
                        s.pcount = '0;
                        s.scl = 1'b0;
                        s.sda = 1'b0;
                    end else begin
                        s.wcount = s.wcount + 8'd1;
                    end
                end else if (ended) begin
                    case (s.step)
                        4'd0: begin
                            s.scl = 1'b1;
                            s.step = 4'd1;
                        end
                        4'd1: begin
                            s.scl = 1'b0;
                            s.step = 4'd2;
                        end
                        4'd2: begin
                            s.bidx = s.bidx + 4'd1;
                            s.shreg = {s.shreg[6:0], 1'b0};
                            if (s.bidx < 4'd8) begin
                                s.sda = s.shreg[7];
                                s.step = 4'd0;
                            end else begin
                                s.step = 4'd3;
                            end
                        end
                        4'd3: begin
                            s.sda = 1'b1;
                            s.scl = 1'b0;
                            s.step = 4'd4;
                        end
                        default: begin
                            s.scl = 1'b1;
                            s.wcount = '0;
                            s.step = ACK_WAIT_STEP;
                        end
                    endcase
                end
            end
            i2cme_pkg::MODE_READ: begin
                if (ended) begin
                    case (s.step)
                        4'd0: begin
                            s.scl = 1'b1;
                            s.step = 4'd1;
                        end
                        4'd1: begin
                            s.shreg = {s.shreg[6:0], w.sda_sample};
                            s.step = 4'd2;
                        end
                        4'd2: begin
                            s.scl = 1'b0;
                            s.bidx = s.bidx + 4'd1;
                            if (s.bidx < 4'd8) begin
                                s.step = 4'd0;
                            end else begin
                                s.sda = ~s.ack_sel;
                                s.step = 4'd3;
                            end
                        end
                        4'd3: begin
                            s.scl = 1'b1;
                            s.step = 4'd4;
                        end
                        default: begin
                            s.scl = 1'b0;
                            s.rx = s.shreg;
                            s.mode = i2cme_pkg::MODE_IDLE;
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            default: s.mode = i2cme_pkg::MODE_IDLE;
        endcase
        r.scl_level    = s.scl;
        r.sda_level    = s.sda;
        r.ready_res    = (s.mode == i2cme_pkg::MODE_IDLE);
        r.done_res     = fin;
        r.rx_byte      = s.rx;
        r.no_ack_error = s.err;
    endtask

    // Driver: feeds queued ticks, holds each word until taken
    always @(posedge clk) begin
        int src_gap;
        if (!rst_n) begin
            in_valid <= 1'b0;
            src_gap = 0;
        end else if (!in_valid || in_ready) begin
            if (idle_en && src_gap > 0) begin
                src_gap--;
                in_valid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                src_gap = int'($urandom_range(0, 7));
                in_valid <= 1'b0;
            end else if (tick_q.size() != 0) begin
                in_valid <= 1'b1;
                in_data <= tick_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the pipeline
    always @(posedge clk) begin
        int stall_left;
        int hold_left;
        bit hold_done;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 600) begin
            hold_done = 1'b1;
            hold_left = 300;
            out_ready <= 1'b0;
        end else if (idle_en && stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = int'($urandom_range(0, 7));
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
    endtask

    // Monitor: predicts on each accepted tick, checks each returned word
    always @(posedge clk) begin
        i2cme_pkg::t_out_word want;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                advance_bus(checked_bus, in_data, want);
                expected_levels_q.push_back(want);
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_levels_q.size() == 0) begin
                    $display("%0t: result word with nothing expected: actual %h",
                             $time, out_data);
                    mismatches++;
                end else begin
                    want = expected_levels_q.pop_front();
                    if (out_data.scl_level !== want.scl_level)
                        report_field("scl_level", 8'(want.scl_level),
                                     8'(out_data.scl_level));
                    if (out_data.sda_level !== want.sda_level)
                        report_field("sda_level", 8'(want.sda_level),
                                     8'(out_data.sda_level));
                    if (out_data.ready_res !== want.ready_res)
                        report_field("ready_res", 8'(want.ready_res),
                                     8'(out_data.ready_res));
                    if (out_data.done_res !== want.done_res)
                        report_field("done_res", 8'(want.done_res),
                                     8'(out_data.done_res));
                    if (out_data.rx_byte !== want.rx_byte)
                        report_field("rx_byte", want.rx_byte, out_data.rx_byte);
                    if (out_data.no_ack_error !== want.no_ack_error)
                        report_field("no_ack_error", 8'(want.no_ack_error),
                                     8'(out_data.no_ack_error));
                end
            end
        end
    end

    task automatic push_tick(input i2cme_pkg::t_in_word w);
        i2cme_pkg::t_out_word unused;
        tick_q.push_back(w);
        advance_bus(lookahead_bus, w, unused);
        ticks_planned++;
    endtask

    // Issue one command, then tick until the engine is idle again.
    // ack_delay: high SDA samples before the ACK; negative never acknowledges.
    task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] data, input logic ack,
                           input int ack_delay);
        i2cme_pkg::t_in_word w;
        int highs;
        highs = 0;
        w.command = cmd;
        w.tx_byte = data;
        w.send_ack = ack;
        w.sda_sample = 1'($urandom_range(0, 1));
        push_tick(w);
        while (lookahead_bus.mode != i2cme_pkg::MODE_IDLE) begin
            // commands offered while busy must be ignored
            w.command = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                    : i2cme_pkg::CMD_NONE;
            w.tx_byte = 8'($urandom);
            w.send_ack = 1'($urandom_range(0, 1));
            if (lookahead_bus.mode == i2cme_pkg::MODE_WRITE &&
                lookahead_bus.step == ACK_WAIT_STEP) begin
                if (ack_delay >= 0 && highs >= ack_delay) begin
                    w.sda_sample = 1'b0;
                end else begin
                    w.sda_sample = 1'b1;
                    highs++;
                end
            end else begin
                w.sda_sample = 1'($urandom_range(0, 1));
            end
            push_tick(w);
        end
    endtask

    function automatic int pick_ack_delay();
        return ($urandom_range(0, 9) == 0) ? -1 : int'($urandom_range(0, 4));
    endfunction

    // Mostly well-formed frames (start, bytes, stop), the rest stray commands
    task automatic random_traffic(input int budget);
        int first;
        int nbytes;
        first = ticks_planned;
        while (ticks_planned - first < budget) begin
            if ($urandom_range(0, 4) != 0) begin
                run_cmd(i2cme_pkg::CMD_START, 8'($urandom), 1'($urandom), 0);
                nbytes = int'($urandom_range(1, 3));
                repeat (nbytes) begin
                    if ($urandom_range(0, 2) == 0)
                        run_cmd(i2cme_pkg::CMD_READ, 8'($urandom), 1'($urandom), 0);
                    else
                        run_cmd(i2cme_pkg::CMD_WRITE, 8'($urandom), 1'($urandom),
                                pick_ack_delay());
                    repeat ($urandom_range(0, 2))
                        run_cmd(i2cme_pkg::CMD_NONE, 8'($urandom), 1'($urandom), 0);
                end
                run_cmd(i2cme_pkg::CMD_STOP, 8'($urandom), 1'($urandom), 0);
            end else begin
                run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                        pick_ack_delay());
            end
        end
    endtask

    // Sampled between edges so the driver's updates have settled
    task automatic wait_drained();
        while (tick_q.size() != 0 || in_valid || expected_levels_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [i2cme_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == i2cme_pkg::REG_PHASE_TICKS)
            phase_len = val;
        else
            ack_limit = val;
    endtask

    // Stimulus sequence
    initial begin
        lookahead_bus = bus_after_reset();
        checked_bus = bus_after_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: every command, byte extremes, ACK timeout, unused codes
        run_cmd(i2cme_pkg::CMD_START, 8'h00, 1'b0, 0);
        run_cmd(i2cme_pkg::CMD_WRITE, 8'hFF, 1'b0, 0);
        run_cmd(i2cme_pkg::CMD_WRITE, 8'h00, 1'b1, 1);
        run_cmd(i2cme_pkg::CMD_WRITE, 8'h5A, 1'b0, -1);
        run_cmd(i2cme_pkg::CMD_READ, 8'hFF, 1'b1, 0);
        run_cmd(i2cme_pkg::CMD_READ, 8'h00, 1'b0, 0);
        run_cmd(i2cme_pkg::CMD_STOP, 8'h00, 1'b0, 0);
        for (int c = int'(i2cme_pkg::CMD_READ) + 1; c <= 7; c++)
            run_cmd(3'(c), 8'hFF, 1'b1, 0);
        run_cmd(i2cme_pkg::CMD_NONE, 8'h00, 1'b0, 0);
        wait_drained();

        // Shortest phase, zero ACK tolerance
        write_reg(i2cme_pkg::REG_PHASE_TICKS, 8'd1);
        write_reg(i2cme_pkg::REG_ACK_TIMEOUT, 8'd0);
        random_traffic(150);
        wait_drained();

        // Zero phase length behaves as one; ACK right at and just past the limit
        write_reg(i2cme_pkg::REG_PHASE_TICKS, 8'd0);
        write_reg(i2cme_pkg::REG_ACK_TIMEOUT, 8'd3);
        run_cmd(i2cme_pkg::CMD_START, 8'($urandom), 1'b0, 0);
        run_cmd(i2cme_pkg::CMD_WRITE, 8'h81, 1'b0, 3);
        run_cmd(i2cme_pkg::CMD_WRITE, 8'h7E, 1'b0, 4);
        run_cmd(i2cme_pkg::CMD_READ, 8'($urandom), 1'b1, 0);
        run_cmd(i2cme_pkg::CMD_STOP, 8'($urandom), 1'b0, 0);
        wait_drained();

        write_reg(i2cme_pkg::REG_PHASE_TICKS, 8'd3);
        write_reg(i2cme_pkg::REG_ACK_TIMEOUT, 8'd255);
        random_traffic(60);
        wait_drained();

        // Final stretch at full rate on both sides
        idle_en = 1'b0;
        write_reg(i2cme_pkg::REG_PHASE_TICKS, 8'd2);
        write_reg(i2cme_pkg::REG_ACK_TIMEOUT, 8'd9);
        random_traffic(120);
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
